/* rtl/irclt_pkg.sv */
// ----------------------------------------------------------------------------
// irclt_pkg
// Shared types, constants and helpers for the IRC line tokenizer.
// ----------------------------------------------------------------------------
package irclt_pkg;

    localparam int DEF_MAX_TOKENS = 16;
    localparam int DEF_MAX_LINE   = 1024;

    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [3:0] {
        MODE_WAIT        = 4'd0,
        MODE_PFX_START   = 4'd1,
        MODE_PFX         = 4'd2,
        MODE_GAP         = 4'd3,
        MODE_TOKEN       = 4'd4,
        MODE_TRAIL_START = 4'd5,
        MODE_TRAIL       = 4'd6,
        MODE_DEAD        = 4'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_PREFIX_ONLY = 2'd1,
        ST_LEAD_SPACE  = 2'd2,
        ST_TOO_LONG    = 2'd3
    } status_t;

    // One result of the parser, valid for one accepted byte.
    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   token_byte;
        logic [SLOT_W-1:0]   slot;
        logic                token_first;
        logic                line_done;
        status_t             line_status;
    } result_t;

    // Status a line would report if it ended in the given state.
    function automatic status_t status_of_mode(input mode_t mode,
                                               input logic [SLOT_W-1:0] slot_idx,
                                               input status_t err);
        status_t st;
        st = ST_OK;
        case (mode)
            MODE_DEAD:      st = err;
            MODE_WAIT:      st = ST_PREFIX_ONLY;
            MODE_PFX_START: st = ST_PREFIX_ONLY;
            MODE_PFX:       st = ST_PREFIX_ONLY;
            MODE_GAP:       st = (slot_idx == SLOT_W'(1)) ? ST_PREFIX_ONLY : ST_OK;
            default:        st = ST_OK;
        endcase
        return st;
    endfunction

endpackage

/* rtl/irc_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Splits a received IRC byte stream into lines and slot-tagged token bytes.
// ----------------------------------------------------------------------------
// Takes one byte per transaction and can take a new byte in every cycle; a
// result appears on the master side in the cycle after the byte that causes it,
// from the single output register behind the parser state machine. The
// slave side stalls only while a held result is not taken. Each token byte
// comes out tagged with its slot (0 prefix, 1 command, 2 and up arguments)
// and a first-byte flag; each line closes with one transaction that has
// tlast set and carries the line status (ok, prefix only, leading space, too
// long). CR and LF end a line and runs of them produce nothing. Bytes beyond
// the length limit (the smaller of the configured limit and MAX_LINE) are
// dropped up to the delimiter and the line reports too long. Write the limit
// register only while the block is idle.
// ----------------------------------------------------------------------------
module irc_line_tokenizer #(
    parameter int MAX_TOKENS = irclt_pkg::DEF_MAX_TOKENS,
    parameter int MAX_LINE   = irclt_pkg::DEF_MAX_LINE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: line_limit
    input  logic                          cfg_we,
    input  logic [irclt_pkg::COUNT_W-1:0] cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [7:0] token_byte, [11:8] slot, 0 pad
    output logic [2:0]                    m_tuser,   // [0] token_first, [2:1] line_status
    output logic                          m_tlast    // line_done
);
    import irclt_pkg::*;

    localparam logic [COUNT_W-1:0] LINE_CAP = COUNT_W'(MAX_LINE);

    logic [COUNT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] eff_limit;
    logic               s_fire;
    result_t            result;

    logic               m_valid_reg,  m_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               first_reg;
    logic               done_reg;
    status_t            status_reg;

    // Hold the limit register; reset gives a limit of 1024 (LIMIT_RESET).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    assign eff_limit = (limit_reg < LINE_CAP) ? limit_reg : LINE_CAP;

    // Accept whenever the output register is empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    irclt_parser #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (s_fire),
        .rx_byte   (s_tdata),
        .limit     (eff_limit),
        .result    (result)
    );

    // Advance the output register on a produced result; drop valid once taken.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (s_fire && result.valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && result.valid) begin
            byte_reg   <= result.token_byte;
            slot_reg   <= result.slot;
            first_reg  <= result.token_first;
            done_reg   <= result.line_done;
            status_reg <= result.line_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, slot_reg, byte_reg};
    assign m_tuser  = {status_reg, first_reg};
    assign m_tlast  = done_reg;

endmodule

/* rtl/irclt_parser.sv */
// ----------------------------------------------------------------------------
// irclt_parser
// Line and token state machine: one byte in, at most one result out.
// ----------------------------------------------------------------------------
module irclt_parser #(
    parameter int MAX_TOKENS = irclt_pkg::DEF_MAX_TOKENS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         byte_fire,
    input  logic [irclt_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [irclt_pkg::COUNT_W-1:0] limit,
    output irclt_pkg::result_t           result
);
    import irclt_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TOKENS - 1);

    mode_t               mode_reg,  mode_next;
    logic [SLOT_W-1:0]   slot_reg,  slot_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    status_t             err_reg,   err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_WAIT;
            slot_reg  <= '0;
            count_reg <= '0;
            err_reg   <= ST_OK;
        end else if (byte_fire) begin
            mode_reg  <= mode_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        err_next   = err_reg;

        result             = '0;
        result.token_byte  = rx_byte;
        result.line_status = ST_OK;

        if (rx_byte == CH_LF || rx_byte == CH_CR) begin
            // Line end: report once, skip delimiter runs.
            if (mode_reg != MODE_WAIT) begin
                result.valid       = 1'b1;
                result.token_byte  = '0;
                result.line_done   = 1'b1;
                result.line_status = status_of_mode(mode_reg, slot_reg, err_reg);
                mode_next  = MODE_WAIT;
                slot_next  = '0;
                count_next = '0;
                err_next   = ST_OK;
            end
        end else if (count_reg >= limit) begin
            mode_next = MODE_DEAD;
            err_next  = ST_TOO_LONG;
        end else begin
            count_next = count_reg + COUNT_W'(1);
            if (mode_reg == MODE_DEAD) begin
                // drop the rest of the line
            end else if (rx_byte == CH_NUL) begin
                err_next  = status_of_mode(mode_reg, slot_reg, err_reg);
                mode_next = MODE_DEAD;
            end else begin
                case (mode_reg)
                    MODE_WAIT: begin
                        if (rx_byte == CH_COLON) begin
                            mode_next = MODE_PFX_START;
                            slot_next = '0;
                        end else if (rx_byte == CH_SPACE) begin
                            mode_next = MODE_DEAD;
                            err_next  = ST_LEAD_SPACE;
                        end else begin
                            mode_next          = MODE_TOKEN;
                            slot_next          = SLOT_W'(1);
                            result.valid       = 1'b1;
                            result.slot        = SLOT_W'(1);
                            result.token_first = 1'b1;
                        end
                    end
                    MODE_PFX_START, MODE_PFX: begin
                        if (rx_byte == CH_SPACE) begin
                            mode_next = MODE_GAP;
                            slot_next = SLOT_W'(1);
                        end else begin
                            mode_next          = MODE_PFX;
                            result.valid       = 1'b1;
                            result.slot        = '0;
                            result.token_first = (mode_reg == MODE_PFX_START);
                        end
                    end
                    MODE_GAP: begin
                        if (rx_byte == CH_SPACE) begin
                            // skip space runs
                        end else if (slot_reg >= SLOT_W'(2) && rx_byte == CH_COLON) begin
                            mode_next = MODE_TRAIL_START;
                        end else begin
                            mode_next = (slot_reg >= LAST_SLOT) ? MODE_TRAIL : MODE_TOKEN;
                            result.valid       = 1'b1;
                            result.slot        = slot_reg;
                            result.token_first = 1'b1;
                        end
                    end
                    MODE_TOKEN: begin
                        if (rx_byte == CH_SPACE) begin
                            mode_next = MODE_GAP;
                            slot_next = slot_reg + SLOT_W'(1);
                        end else begin
                            result.valid = 1'b1;
                            result.slot  = slot_reg;
                        end
                    end
                    MODE_TRAIL_START: begin
                        mode_next          = MODE_TRAIL;
                        result.valid       = 1'b1;
                        result.slot        = slot_reg;
                        result.token_first = 1'b1;
                    end
                    MODE_TRAIL: begin
                        result.valid = 1'b1;
                        result.slot  = slot_reg;
                    end
                    default: begin
                        mode_next = MODE_DEAD;
                    end
                endcase
            end
        end
    end

endmodule
